FILE: rtl/core/random_kruskal_maze_builder_defines.svh
// assertion macros shared by the maze builder checker
`ifndef RANDOM_KRUSKAL_MAZE_BUILDER_DEFINES_SVH
`define RANDOM_KRUSKAL_MAZE_BUILDER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RKM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RKM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rkm_pkg.sv
// shared types, constants and helpers of the maze builder
`default_nettype none

package rkm_pkg;

  localparam int MAX_CELLS = 4096;
  localparam int MAX_SIDE  = 64;
  localparam int CELL_W    = 12;
  localparam int SIDE_W    = 7;
  localparam int STATUS_W  = 3;
  localparam int CELLS_W   = CELL_W + 1;
  localparam int DIV_CNT_W = $clog2(CELL_W);
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam logic [SIDE_W-1:0] GRID_RESET = SIDE_W'(8);

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REMOVED      = 3'd0,
    ST_EDGE         = 3'd1,
    ST_WALL_GONE    = 3'd2,
    ST_SAME_SET     = 3'd3,
    ST_OUT_OF_RANGE = 3'd4,
    ST_COMPLETE     = 3'd5
  } status_t;

  // one store word per cell
  typedef struct packed {
    logic [CELL_W-1:0] parent;
    logic              right_wall;
    logic              down_wall;
  } cell_word_t;

  typedef enum logic [1:0] {
    ADDR_CELL,
    ADDR_NB,
    ADDR_WALK
  } addr_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_CELL,
    WR_ROOT
  } wr_sel_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DIV,
    S_CHECK,
    S_RD_CELL,
    S_WALK_A,
    S_WALK_B,
    S_WR_CELL,
    S_WR_ROOT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic      load;
    logic      clear_step;
    logic      div_step;
    logic      set_cur;
    logic      walk;
    logic      start_b;
    logic      cap_cell;
    logic      cap_rb;
    logic      inc_count;
    logic      status_wr;
    status_t   status_code;
    addr_sel_t addr_sel;
    wr_sel_t   wr_sel;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic    new_maze;
    logic    clr_last;
    logic    div_last;
    logic    early_hit;
    status_t early_code;
    logic    wall_gone;
    logic    root_hit;
    logic    same_set;
    logic    out_free;
  } dp_sts_t;

  // side register value forced into 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_SIDE)) r = SIDE_W'(MAX_SIDE);
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rkm_in_if.sv
// draw request channel
`default_nettype none

interface rkm_in_if;
  import rkm_pkg::*;
  logic              valid;
  logic              ready;
  logic              new_maze;
  logic [CELL_W-1:0] cell_req;
  logic              toward_right;

  modport source (output valid, output new_maze, output cell_req, output toward_right,
                  input ready);
  modport sink   (input valid, input new_maze, input cell_req, input toward_right,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rkm_out_if.sv
// result channel
`default_nettype none

interface rkm_out_if;
  import rkm_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CELL_W-1:0]   removed_total;
  logic                complete;

  modport source (output valid, output status, output removed_total, output complete,
                  input ready);
  modport sink   (input valid, input status, input removed_total, input complete,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/rkm_cfg.sv
// grid size registers behind the apb port
`default_nettype none

module rkm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rkm_pkg::ADDR_W-1:0] paddr,
  input  logic [rkm_pkg::DATA_W-1:0] pwdata,
  output logic [rkm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output logic [rkm_pkg::SIDE_W-1:0] grid_width,
  output logic [rkm_pkg::SIDE_W-1:0] grid_height
);
  import rkm_pkg::*;

  logic [SIDE_W-1:0] grid_width_r, grid_width_nxt;
  logic [SIDE_W-1:0] grid_height_r, grid_height_nxt;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register write decode
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    if (wr_en) begin
      case (paddr[2])
        REG_GRID_WIDTH:  grid_width_nxt  = pwdata[SIDE_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = pwdata[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_RESET;
      grid_height_r <= GRID_RESET;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width_r);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height_r);
      default:         prdata = '0;
    endcase
  end

  assign grid_width  = grid_width_r;
  assign grid_height = grid_height_r;

endmodule

`default_nettype wire

FILE: rtl/core/rkm_dp.sv
// datapath: cell store, root walks, column divider and result register
`default_nettype none

module rkm_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rkm_pkg::SIDE_W-1:0]   grid_width,
  input  logic [rkm_pkg::SIDE_W-1:0]   grid_height,
  input  rkm_pkg::dp_cmd_t             cmd,
  output rkm_pkg::dp_sts_t             sts,
  input  logic                         in_new_maze,
  input  logic [rkm_pkg::CELL_W-1:0]   in_cell_req,
  input  logic                         in_toward_right,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rkm_pkg::STATUS_W-1:0] out_status,
  output logic [rkm_pkg::CELL_W-1:0]   out_removed_total,
  output logic                         out_complete
);
  import rkm_pkg::*;

  cell_word_t mem [MAX_CELLS];
  cell_word_t rd_q_r;
  cell_word_t cell_word_r;
  cell_word_t rb_word_r;
  cell_word_t wr_data;

  logic [CELL_W-1:0]    rd_addr, wr_addr, nb;
  logic                 wr_en;
  logic [CELL_W-1:0]    cell_r, cur_r, ra_r, count_r, clr_idx_r;
  logic                 right_r, new_r;
  logic [SIDE_W-1:0]    w_c, h_c, rem_r, rem_sh;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CELLS_W-1:0]   cells_r, target, cw_sum;
  logic                 complete_now, oor, on_edge;
  logic                 early_hit;
  status_t              early_code;
  status_t              status_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [CELL_W-1:0]    out_total_r;
  logic                 out_complete_r;

  // geometry from the clamped registers
  assign w_c = clamp_side(grid_width);
  assign h_c = clamp_side(grid_height);

  always_ff @(posedge clk) begin
    cells_r <= CELLS_W'(14'(w_c) * 14'(h_c));
  end

  assign target       = cells_r - CELLS_W'(1);
  assign complete_now = {1'b0, count_r} >= target;
  assign oor          = {1'b0, cell_r} >= cells_r;
  assign cw_sum       = {1'b0, cell_r} + CELLS_W'(w_c);
  assign on_edge      = right_r ? (rem_r == w_c - SIDE_W'(1)) : (cw_sum >= cells_r);
  assign nb           = right_r ? cell_r + CELL_W'(1) : cell_r + CELL_W'(w_c);

  // early outcome, in priority order
  always_comb begin
    early_hit  = 1'b1;
    early_code = ST_COMPLETE;
    if (complete_now)  early_code = ST_COMPLETE;
    else if (oor)      early_code = ST_OUT_OF_RANGE;
    else if (on_edge)  early_code = ST_EDGE;
    else               early_hit  = 1'b0;
  end

  assign sts.early_hit  = early_hit;
  assign sts.early_code = early_code;
  assign sts.new_maze   = new_r;
  assign sts.clr_last   = clr_idx_r == '1;
  assign sts.div_last   = div_cnt_r == DIV_CNT_W'(CELL_W - 1);
  assign sts.wall_gone  = right_r ? !rd_q_r.right_wall : !rd_q_r.down_wall;
  assign sts.root_hit   = rd_q_r.parent == cur_r;
  assign sts.same_set   = cur_r == ra_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  // read address select
  always_comb begin
    case (cmd.addr_sel)
      ADDR_CELL: rd_addr = cell_r;
      ADDR_NB:   rd_addr = nb;
      ADDR_WALK: rd_addr = rd_q_r.parent;
      default:   rd_addr = cell_r;
    endcase
  end

  // write select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cell_r;
    wr_data = cell_word_r;
    case (cmd.wr_sel)
      WR_CLEAR: begin
        wr_addr = clr_idx_r;
        wr_data = '{parent: clr_idx_r, right_wall: 1'b1, down_wall: 1'b1};
      end
      WR_CELL: begin
        wr_addr = cell_r;
        wr_data = cell_word_r;
        if (right_r) wr_data.right_wall = 1'b0;
        else         wr_data.down_wall  = 1'b0;
      end
      WR_ROOT: begin
        wr_addr = cur_r;
        wr_data = '{parent: ra_r, right_wall: rb_word_r.right_wall,
                    down_wall: rb_word_r.down_wall};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // cell store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q_r <= mem[rd_addr];
  end

  // request fields, walk pointers and captured words
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_r  <= in_cell_req;
      right_r <= in_toward_right;
      new_r   <= in_new_maze;
    end
    if (cmd.set_cur) cur_r <= cell_r;
    else if (cmd.start_b) begin
      ra_r  <= cur_r;
      cur_r <= nb;
    end else if (cmd.walk) cur_r <= rd_q_r.parent;
    if (cmd.cap_cell) cell_word_r <= rd_q_r;
    if (cmd.cap_rb)   rb_word_r   <= rd_q_r;
    if (cmd.status_wr) status_r <= cmd.status_code;
  end

  // column of the cell, one quotient bit a cycle
  assign rem_sh = {rem_r[SIDE_W-2:0], cell_r[DIV_CNT_W'(CELL_W - 1) - div_cnt_r]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= (rem_sh >= w_c) ? rem_sh - w_c : rem_sh;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // clearing sweep and removal count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      count_r   <= '0;
    end else begin
      if (cmd.clear_step) clr_idx_r <= clr_idx_r + CELL_W'(1);
      if (cmd.clear_step && sts.clr_last) count_r <= '0;
      else if (cmd.inc_count)             count_r <= count_r + CELL_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r   <= status_r;
      out_total_r    <= count_r;
      out_complete_r <= complete_now;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_total = out_total_r;
  assign out_complete      = out_complete_r;

endmodule

`default_nettype wire

FILE: rtl/core/rkm_ctrl.sv
// controller: sequences clear, divide, check, two root walks and the join
`default_nettype none

module rkm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_new_maze,
  output logic             in_ready,
  input  rkm_pkg::dp_sts_t sts,
  output rkm_pkg::dp_cmd_t cmd
);
  import rkm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else        state_r <= state_nxt;
  end

  assign in_ready = state_r == S_IDLE;

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.status_code = ST_REMOVED;
    cmd.addr_sel    = ADDR_CELL;
    cmd.wr_sel      = WR_NONE;
    case (state_r)
      S_INIT: begin
        cmd.clear_step = 1'b1;
        cmd.wr_sel     = WR_CLEAR;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_new_maze ? S_CLEAR : S_DIV;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        cmd.wr_sel     = WR_CLEAR;
        if (sts.clr_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.set_cur  = 1'b1;
        cmd.addr_sel = ADDR_CELL;
        if (sts.early_hit) begin
          cmd.status_wr   = 1'b1;
          cmd.status_code = sts.early_code;
          state_nxt       = S_FINISH;
        end else begin
          state_nxt = S_RD_CELL;
        end
      end
      S_RD_CELL: begin
        cmd.cap_cell = 1'b1;
        if (sts.wall_gone) begin
          cmd.status_wr   = 1'b1;
          cmd.status_code = ST_WALL_GONE;
          state_nxt       = S_FINISH;
        end else if (sts.root_hit) begin
          cmd.start_b  = 1'b1;
          cmd.addr_sel = ADDR_NB;
          state_nxt    = S_WALK_B;
        end else begin
          cmd.walk     = 1'b1;
          cmd.addr_sel = ADDR_WALK;
          state_nxt    = S_WALK_A;
        end
      end
      S_WALK_A: begin
        if (sts.root_hit) begin
          cmd.start_b  = 1'b1;
          cmd.addr_sel = ADDR_NB;
          state_nxt    = S_WALK_B;
        end else begin
          cmd.walk     = 1'b1;
          cmd.addr_sel = ADDR_WALK;
        end
      end
      S_WALK_B: begin
        if (sts.root_hit) begin
          cmd.cap_rb = 1'b1;
          if (sts.same_set) begin
            cmd.status_wr   = 1'b1;
            cmd.status_code = ST_SAME_SET;
            state_nxt       = S_FINISH;
          end else begin
            state_nxt = S_WR_CELL;
          end
        end else begin
          cmd.walk     = 1'b1;
          cmd.addr_sel = ADDR_WALK;
        end
      end
      S_WR_CELL: begin
        cmd.wr_sel = WR_CELL;
        state_nxt  = S_WR_ROOT;
      end
      S_WR_ROOT: begin
        cmd.wr_sel      = WR_ROOT;
        cmd.inc_count   = 1'b1;
        cmd.status_wr   = 1'b1;
        cmd.status_code = ST_REMOVED;
        state_nxt       = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/random_kruskal_maze_builder.sv
// After reset a clearing pass restores the store; no request is taken meanwhile.
// One request at a time: accept, divide, check and cell read, then one step per link
// of root chain A and one per cell of chain B, the cell and root writes for a join, and the result load.
// new_maze adds a clearing pass; a stalled result register holds the last state.
// The next request is taken while the result still waits in the output register.
`default_nettype none

module random_kruskal_maze_builder (
  input  logic                       clk,
  input  logic                       rst_n,
  rkm_in_if.sink                     in_ch,
  rkm_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rkm_pkg::ADDR_W-1:0] paddr,
  input  logic [rkm_pkg::DATA_W-1:0] pwdata,
  output logic [rkm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import rkm_pkg::*;

  logic [SIDE_W-1:0] grid_width, grid_height;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  rkm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .grid_width  (grid_width),
    .grid_height (grid_height)
  );

  rkm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_new_maze (in_ch.new_maze),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  rkm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .grid_width        (grid_width),
    .grid_height       (grid_height),
    .cmd               (cmd),
    .sts               (sts),
    .in_new_maze       (in_ch.new_maze),
    .in_cell_req       (in_ch.cell_req),
    .in_toward_right   (in_ch.toward_right),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_removed_total (out_ch.removed_total),
    .out_complete      (out_ch.complete)
  );

endmodule

`default_nettype wire

FILE: rtl/core/rkm_checker.sv
// port-level checks of the maze builder, bound to the top level
`default_nettype none
`include "random_kruskal_maze_builder_defines.svh"

module rkm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [rkm_pkg::STATUS_W-1:0] out_status,
  input logic [rkm_pkg::CELL_W-1:0]   out_removed_total,
  input logic                         out_complete
);
  import rkm_pkg::*;

  // a stalled result holds
  `RKM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_removed_total), "result dropped while stalled")
  // one request at a time
  `RKM_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
  // only defined result codes
  `RKM_ASSERT_IMP(a_code_legal, out_valid, out_status <= STATUS_W'(ST_COMPLETE), "undefined result code")
  // complete code only when the maze is complete
  `RKM_ASSERT_IMP(a_done_flag, out_valid && out_status == STATUS_W'(ST_COMPLETE), out_complete, "complete code without complete flag")
  // a removal leaves a nonzero count
  `RKM_ASSERT_IMP(a_removed_count, out_valid && out_status == STATUS_W'(ST_REMOVED), out_removed_total != '0, "removal with zero count")

endmodule

bind random_kruskal_maze_builder rkm_checker u_rkm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_removed_total (out_ch.removed_total),
  .out_complete      (out_ch.complete)
);

`default_nettype wire
